>>> design/tgl_pkg.sv
package tgl_pkg;

   localparam int unsigned WORD_W        = 32;
   localparam int unsigned WIDE_W        = 40;
   localparam int unsigned LINES_W       = 16;
   localparam int unsigned CODE_W        = 8;
   localparam int unsigned CSR_IDX_W     = 3;
   localparam int unsigned FRAC_BITS_DEF = 16;

   // input opcodes
   localparam logic [1:0] OP_GLYPH   = 2'd0;
   localparam logic [1:0] OP_NEWLINE = 2'd1;
   localparam logic [1:0] OP_IGNORE  = 2'd2;
   localparam logic [1:0] OP_END     = 2'd3;

   // result kinds
   localparam logic KIND_GLYPH  = 1'b0;
   localparam logic KIND_BOUNDS = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_STEP = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPACING   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WRAP      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ASCENT    = 3'd4;

   localparam logic [WORD_W-1:0] SCALE_RST     = 32'h0001_0000;
   localparam logic [WORD_W-1:0] LINE_STEP_RST = 32'h0001_0000;

   localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
   localparam logic [LINES_W-1:0]       LINES_MAX = 16'hFFFF;
   localparam logic [LINES_W-1:0]       LINES_ONE = 16'd1;

   typedef struct packed {
      logic [1:0]               opcode;
      logic signed [WORD_W-1:0] box_left;
      logic signed [WORD_W-1:0] box_right;
      logic signed [WORD_W-1:0] box_top;
      logic signed [WORD_W-1:0] box_bottom;
      logic signed [WORD_W-1:0] advance;
      logic signed [WORD_W-1:0] kern_adjust;
      logic [CODE_W-1:0]        char_code;
   } tgl_req_type;

   typedef struct packed {
      logic                     kind;
      logic signed [WORD_W-1:0] pos_x;
      logic signed [WORD_W-1:0] pos_y;
      logic signed [WORD_W-1:0] box_width;
      logic signed [WORD_W-1:0] box_height;
      logic [CODE_W-1:0]        placed_code;
      logic [LINES_W-1:0]       lines;
   } tgl_rsp_type;

   function automatic logic signed [WIDE_W-1:0] sext_wide(input logic signed [WORD_W-1:0] v);
      sext_wide = {{(WIDE_W-WORD_W){v[WORD_W-1]}}, v};
   endfunction

   // clamp a wide signed value to the 32-bit signed range
   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WIDE_W-1:0] v);
      logic [WIDE_W-WORD_W:0] top_bits;
      top_bits = v[WIDE_W-1:WORD_W-1];
      if ((&top_bits) || !(|top_bits)) begin
         sat_word = v[WORD_W-1:0];
      end else if (v[WIDE_W-1]) begin
         sat_word = WORD_MIN;
      end else begin
         sat_word = WORD_MAX;
      end
   endfunction

endpackage

>>> design/tgl_scaler.sv
module tgl_scaler #(
   parameter int unsigned FRAC_BITS = tgl_pkg::FRAC_BITS_DEF
) (
   input  logic signed [tgl_pkg::WORD_W-1:0] value,
   input  logic [tgl_pkg::WORD_W-1:0]        scale,
   output logic signed [tgl_pkg::WORD_W-1:0] result
);
   import tgl_pkg::*;

   localparam int unsigned PROD_W = 2 * WORD_W + 1;

   logic signed [PROD_W-1:0]  product;
   logic signed [PROD_W-1:0]  shifted;
   logic [PROD_W-WORD_W:0]    top_bits;

   // signed value times unsigned scale, floor toward minus infinity
   assign product  = $signed({{(WORD_W+1){value[WORD_W-1]}}, value})
                   * $signed({{(WORD_W+1){1'b0}}, scale});
   assign shifted  = product >>> FRAC_BITS;
   assign top_bits = shifted[PROD_W-1:WORD_W-1];

   always_comb begin
      if ((&top_bits) || !(|top_bits)) begin
         result = shifted[WORD_W-1:0];
      end else if (shifted[PROD_W-1]) begin
         result = WORD_MIN;
      end else begin
         result = WORD_MAX;
      end
   end

endmodule

>>> design/text_glyph_layout_unit.sv
// Greedy text line layout with kerning. Character items enter on req_ and
// placed glyph boxes or final text bounds leave on rsp_. The block takes one
// item per clock while rsp_ready holds; a result shows on rsp_ from the
// output register, and newline or ignored items leave no result. Four
// register stages: input, six parallel font-unit scalers (value times
// scale), the pen/line state update, and the bounds height multiply into the
// output register. The recurrence on pen, widest line and line count in
// stage three sets the rate of one item per cycle when unstalled; every stage
// stalls on its own, so bubbles close up behind a stalled output. Registers
// are written on csr_, which is always ready; write them only with the
// block drained (no result pending and a few cycles since the last item).
module text_glyph_layout_unit #(
   parameter int unsigned FRAC_BITS = tgl_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  tgl_pkg::tgl_req_type                req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output tgl_pkg::tgl_rsp_type                rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tgl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tgl_pkg::WORD_W-1:0]          csr_wdata
);
   import tgl_pkg::*;

   // configuration
   logic [WORD_W-1:0]        scale_ff;
   logic signed [WORD_W-1:0] line_step_ff;
   logic signed [WORD_W-1:0] spacing_ff;
   logic signed [WORD_W-1:0] wrap_width_ff;
   logic signed [WORD_W-1:0] ascent_ff;

   // layout state
   logic signed [WORD_W-1:0] pen_x_ff, pen_x_in;
   logic signed [WORD_W-1:0] pen_y_ff, pen_y_in;
   logic signed [WORD_W-1:0] widest_ff, widest_in;
   logic [LINES_W-1:0]       line_total_ff, line_total_in;
   logic                     have_prev_ff, have_prev_in;
   logic                     text_seen_ff, text_seen_in;

   // stage valids and readies
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic r1, r2, r3, r4;

   // stage 1: input register
   tgl_req_type req_ff;

   // stage 2: scaled values
   logic [1:0]               op2_ff;
   logic [CODE_W-1:0]        code2_ff;
   logic signed [WORD_W-1:0] gw2_ff, gh2_ff, sl2_ff, asc2_ff, adv2_ff, kern2_ff;
   logic signed [WORD_W-1:0] gw_in, gh_in, sl_in, asc_in, adv_in, kern_in;
   logic signed [WORD_W-1:0] diff_w, diff_h, diff_a;

   // stage 3: layout result
   tgl_rsp_type        out3_ff, out3_in;
   logic [LINES_W-1:0] tot3_ff;
   logic               has_result;
   logic               xfer2;

   // stage 4: output register
   tgl_rsp_type              rsp_ff, rsp_in;
   logic signed [48:0]       height_prod;
   logic [48-WORD_W+1:0]     height_top;
   logic signed [WORD_W-1:0] height;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff      <= SCALE_RST;
         line_step_ff  <= LINE_STEP_RST;
         spacing_ff    <= '0;
         wrap_width_ff <= '0;
         ascent_ff     <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SCALE:     scale_ff      <= csr_wdata;
            CSR_LINE_STEP: line_step_ff  <= csr_wdata;
            CSR_SPACING:   spacing_ff    <= csr_wdata;
            CSR_WRAP:      wrap_width_ff <= csr_wdata;
            CSR_ASCENT:    ascent_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // per-stage flow control; a stage takes a new item when empty or draining
   assign r4 = !v4_ff || rsp_ready;
   assign r3 = !v3_ff || r4;
   assign r2 = !v2_ff || r3;
   assign r1 = !v1_ff || r2;
   assign req_ready = r1;

   // ---------------- stage 1 ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (r1) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (r1 && req_valid) begin
         req_ff <= req_data;
      end
   end

   // ---------------- stage 2: scaling ----------------
   // differences saturate to 32 bits before they are scaled
   assign diff_w = sat_word(sext_wide(req_ff.box_right) - sext_wide(req_ff.box_left));
   assign diff_h = sat_word(sext_wide(req_ff.box_top) - sext_wide(req_ff.box_bottom));
   assign diff_a = sat_word(sext_wide(ascent_ff) - sext_wide(req_ff.box_top));

   tgl_scaler #(.FRAC_BITS(FRAC_BITS)) u_scale_w (
      .value(diff_w), .scale(scale_ff), .result(gw_in));
   tgl_scaler #(.FRAC_BITS(FRAC_BITS)) u_scale_h (
      .value(diff_h), .scale(scale_ff), .result(gh_in));
   tgl_scaler #(.FRAC_BITS(FRAC_BITS)) u_scale_l (
      .value(req_ff.box_left), .scale(scale_ff), .result(sl_in));
   tgl_scaler #(.FRAC_BITS(FRAC_BITS)) u_scale_a (
      .value(diff_a), .scale(scale_ff), .result(asc_in));
   tgl_scaler #(.FRAC_BITS(FRAC_BITS)) u_scale_adv (
      .value(req_ff.advance), .scale(scale_ff), .result(adv_in));
   tgl_scaler #(.FRAC_BITS(FRAC_BITS)) u_scale_kern (
      .value(req_ff.kern_adjust), .scale(scale_ff), .result(kern_in));

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (r2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (r2 && v1_ff) begin
         op2_ff   <= req_ff.opcode;
         code2_ff <= req_ff.char_code;
         gw2_ff   <= gw_in;
         gh2_ff   <= gh_in;
         sl2_ff   <= sl_in;
         asc2_ff  <= asc_in;
         adv2_ff  <= adv_in;
         kern2_ff <= kern_in;
      end
   end

   // ---------------- stage 3: layout state ----------------
   assign xfer2      = v2_ff && r3;
   assign has_result = (op2_ff == OP_GLYPH) || (op2_ff == OP_END);

   always_comb begin
      logic signed [WORD_W-1:0] pen_k;
      logic signed [WIDE_W-1:0] reach;
      logic signed [WIDE_W-1:0] adv_sp;
      logic signed [WORD_W-1:0] y_next;
      logic signed [WORD_W-1:0] widest_max;
      logic signed [WORD_W-1:0] widest_k;
      logic [LINES_W-1:0]       total_inc;
      logic                     wrap;

      pen_x_in      = pen_x_ff;
      pen_y_in      = pen_y_ff;
      widest_in     = widest_ff;
      line_total_in = line_total_ff;
      have_prev_in  = have_prev_ff;
      text_seen_in  = text_seen_ff;
      out3_in       = '0;

      // kerning only against a glyph already on this line
      pen_k = have_prev_ff ? sat_word(sext_wide(pen_x_ff) + sext_wide(kern2_ff)) : pen_x_ff;
      // right edge of the glyph if placed here, exact
      reach  = sext_wide(pen_k) + sext_wide(sl2_ff) + sext_wide(gw2_ff);
      adv_sp = sext_wide(adv2_ff) + sext_wide(spacing_ff);
      y_next = sat_word(sext_wide(pen_y_ff) + sext_wide(line_step_ff));
      total_inc = (line_total_ff == LINES_MAX) ? line_total_ff : line_total_ff + LINES_ONE;
      widest_max = (pen_x_ff > widest_ff) ? pen_x_ff : widest_ff;
      widest_k   = (pen_k > widest_ff) ? pen_k : widest_ff;
      wrap = (wrap_width_ff > 0) && (gw2_ff > 0) && (pen_k > 0)
          && (reach > sext_wide(wrap_width_ff));

      unique case (op2_ff)
         OP_GLYPH: begin
            out3_in.kind        = KIND_GLYPH;
            out3_in.box_width   = gw2_ff;
            out3_in.box_height  = gh2_ff;
            out3_in.placed_code = code2_ff;
            if (wrap) begin
               widest_in     = widest_k;
               pen_y_in      = y_next;
               line_total_in = total_inc;
               out3_in.pos_x = sl2_ff;
               out3_in.pos_y = sat_word(sext_wide(y_next) + sext_wide(asc2_ff));
               pen_x_in      = sat_word(adv_sp);
            end else begin
               out3_in.pos_x = sat_word(sext_wide(pen_k) + sext_wide(sl2_ff));
               out3_in.pos_y = sat_word(sext_wide(pen_y_ff) + sext_wide(asc2_ff));
               pen_x_in      = sat_word(sext_wide(pen_k) + adv_sp);
            end
            have_prev_in = 1'b1;
            text_seen_in = 1'b1;
         end
         OP_NEWLINE: begin
            widest_in     = widest_max;
            pen_x_in      = '0;
            pen_y_in      = y_next;
            line_total_in = total_inc;
            have_prev_in  = 1'b0;
            text_seen_in  = 1'b1;
         end
         OP_IGNORE: begin
            text_seen_in = 1'b1;
         end
         OP_END: begin
            out3_in.kind      = KIND_BOUNDS;
            out3_in.box_width = widest_max;
            out3_in.lines     = text_seen_ff ? line_total_ff : '0;
            // back to the empty-text state
            pen_x_in      = '0;
            pen_y_in      = '0;
            widest_in     = '0;
            line_total_in = LINES_ONE;
            have_prev_in  = 1'b0;
            text_seen_in  = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff      <= '0;
         pen_y_ff      <= '0;
         widest_ff     <= '0;
         line_total_ff <= LINES_ONE;
         have_prev_ff  <= 1'b0;
         text_seen_ff  <= 1'b0;
      end else if (xfer2) begin
         pen_x_ff      <= pen_x_in;
         pen_y_ff      <= pen_y_in;
         widest_ff     <= widest_in;
         line_total_ff <= line_total_in;
         have_prev_ff  <= have_prev_in;
         text_seen_ff  <= text_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (r3) begin
         v3_ff <= v2_ff && has_result;
      end
   end

   // line count kept apart for the height multiply, even for empty text
   always_ff @(posedge clock) begin
      if (xfer2 && has_result) begin
         out3_ff <= out3_in;
         tot3_ff <= line_total_ff;
      end
   end

   // ---------------- stage 4: bounds height, output register ----------------
   assign height_prod = $signed({{(49-LINES_W){1'b0}}, tot3_ff})
                      * $signed({{(49-WORD_W){line_step_ff[WORD_W-1]}}, line_step_ff});
   assign height_top  = height_prod[48:WORD_W-1];

   always_comb begin
      if ((&height_top) || !(|height_top)) begin
         height = height_prod[WORD_W-1:0];
      end else if (height_prod[48]) begin
         height = WORD_MIN;
      end else begin
         height = WORD_MAX;
      end
   end

   // bounds take the computed height, glyphs keep their own
   always_comb begin
      rsp_in = out3_ff;
      if (out3_ff.kind == KIND_BOUNDS) begin
         rsp_in.box_height = height;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (r4) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (r4 && v3_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = v4_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // bounds carry no glyph position or code
   a_bounds_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_BOUNDS) |->
         (rsp_data.pos_x == '0) && (rsp_data.pos_y == '0) && (rsp_data.placed_code == '0))
      else $error("bounds item carries glyph fields");

   // glyph items never report a line count
   a_glyph_lines: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_GLYPH) |-> (rsp_data.lines == '0))
      else $error("glyph item with nonzero line count");

   // the line count never wraps to zero
   a_lines_nonzero: assert property (@(posedge clock) disable iff (reset)
      line_total_ff != '0)
      else $error("line count reached zero");

   // an end item leaves the layout state empty
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      xfer2 && (op2_ff == OP_END) |=>
         (pen_x_ff == '0) && (pen_y_ff == '0) && (widest_ff == '0)
         && (line_total_ff == LINES_ONE) && !have_prev_ff && !text_seen_ff)
      else $error("layout state not cleared after end item");
`endif

endmodule
